// ----- design/assert_macros.svh -----
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, skipped while reset is asserted.
`define TDFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TDFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/tdfp_pkg.sv -----
`timescale 1ns / 1ps

package tdfp_pkg;

  // Default table geometry.
  localparam int DEF_PAGES        = 4;
  localparam int DEF_BUTTON_SLOTS = 256;
  localparam int DEF_VALUE_SLOTS  = 16;

  // Frame header and trailer bytes.
  localparam logic [7:0] HDR_TOUCH = 8'h65;
  localparam logic [7:0] HDR_VALUE = 8'h71;
  localparam logic [7:0] HDR_PAGE  = 8'h66;
  localparam logic [7:0] END_MARK  = 8'hFF;

  // Request kinds carried on the input tuser.
  typedef enum logic [2:0] {
    REQ_RX_BYTE    = 3'd0,
    REQ_FRAME_ERR  = 3'd1,
    REQ_READ_BTN   = 3'd2,
    REQ_RDCLR_BTN  = 3'd3,
    REQ_CLEAR_BTN  = 3'd4,
    REQ_READ_VALUE = 3'd5
  } req_type_e;

  // Completed frame kinds carried on the output tuser.
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_TOUCH = 2'd1,
    EV_VALUE = 2'd2,
    EV_PAGE  = 2'd3
  } frame_event_e;

endpackage

// ----- design/touch_display_frame_parser.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel      | Dir | tdata (low bit up)                                 | tuser
// s_axis       | in  | rx_byte[7:0], query_page[9:8], query_addr[17:10]   | req_type[2:0]
// m_axis       | out | button_state, value_byte, current_page, last_button| frame_event[1:0]
//
// Unless stalled, one transaction is taken per cycle, with its result out the next cycle.
// Each transaction reads and writes the button and value tables through one write
// port and one registered read port each; the read is read-first, so a read-and-clear
// returns the old entry while writing zero in the same cycle.
// After reset a clearing pass writes zero to every table entry, one entry per cycle;
// no transaction is taken then. A stalled result holds in the output register; a new
// transaction is taken in the cycle the held result leaves.

module touch_display_frame_parser #(
  parameter int PAGES        = tdfp_pkg::DEF_PAGES,
  parameter int BUTTON_SLOTS = tdfp_pkg::DEF_BUTTON_SLOTS,
  parameter int VALUE_SLOTS  = tdfp_pkg::DEF_VALUE_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // rx_byte [7:0], query_page [9:8], query_addr [17:10], zeros [23:18]
  input  logic [23:0] s_axis_tdata_i,
  // req_type [2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // button_state [7:0], value_byte [15:8], current_page [23:16], last_button [31:24]
  output logic [31:0] m_axis_tdata_o,
  // frame_event [1:0]
  output logic [1:0]  m_axis_tuser_o
);

  import tdfp_pkg::*;

  // Table sizes and address widths follow from the geometry parameters.
  localparam int BTN_DEPTH = PAGES * BUTTON_SLOTS;
  localparam int VAL_DEPTH = PAGES * VALUE_SLOTS;
  localparam int CLR_DEPTH = (BTN_DEPTH > VAL_DEPTH) ? BTN_DEPTH : VAL_DEPTH;
  localparam int BTN_AW = (BTN_DEPTH > 1) ? $clog2(BTN_DEPTH) : 1;
  localparam int VAL_AW = (VAL_DEPTH > 1) ? $clog2(VAL_DEPTH) : 1;
  localparam int CLR_AW = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  localparam logic [8:0]        PagesC    = 9'(PAGES);
  localparam logic [8:0]        BtnSlotsC = 9'(BUTTON_SLOTS);
  localparam logic [8:0]        ValSlotsC = 9'(VALUE_SLOTS);
  localparam logic [16:0]       BtnDepthC = 17'(BTN_DEPTH);
  localparam logic [16:0]       ValDepthC = 17'(VAL_DEPTH);
  localparam logic [15:0]       BtnMulC   = 16'(BUTTON_SLOTS);
  localparam logic [15:0]       ValMulC   = 16'(VALUE_SLOTS);
  localparam logic [CLR_AW-1:0] ClrLastC  = CLR_AW'(CLR_DEPTH - 1);

  // Input fields.
  req_type_e  req;
  logic [7:0] rx_byte;
  logic [1:0] query_page;
  logic [7:0] query_addr;
  logic       accept;

  assign req        = req_type_e'(s_axis_tuser_i);
  assign rx_byte    = s_axis_tdata_i[7:0];
  assign query_page = s_axis_tdata_i[9:8];
  assign query_addr = s_axis_tdata_i[17:10];

  // Frame collection state.
  logic [7:0] frame_q [8];
  logic [3:0] byte_cnt_q, byte_cnt_d;
  logic [7:0] page_q, page_d;
  logic [7:0] last_addr_q, last_addr_d;
  logic       frame_we;

  // Clearing pass state.
  logic              clearing_q;
  logic [CLR_AW-1:0] clr_cnt_q;

  // Output register.
  logic         out_valid_q;
  logic         out_btn_q;
  logic         out_val_q;
  frame_event_e out_event_q;

  // Table memories and their registered read data.
  logic [7:0] btn_mem [BTN_DEPTH];
  logic [7:0] val_mem [VAL_DEPTH];
  logic [7:0] btn_rd_q;
  logic [7:0] val_rd_q;

  // Table access requests made by the current transaction.
  frame_event_e event_d;
  logic         touch_we;
  logic         value_we;
  logic         btn_ok;
  logic         val_ok;
  logic         btn_rd_en;
  logic         btn_clr_we;
  logic         val_rd_en;
  logic [7:0]   hdr;
  logic         hdr_ok;

  logic [15:0]       touch_idx, value_idx, qbtn_idx, qval_idx;
  logic              btn_we, val_we;
  logic [BTN_AW-1:0] btn_wa;
  logic [7:0]        btn_wd;
  logic [VAL_AW-1:0] val_wa;
  logic [7:0]        val_wd;

  // A new transaction enters whenever no clearing pass runs and the output register is empty or draining.
  assign s_axis_tready_o = !clearing_q && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // The first byte of a frame is the header; once a frame is open its header is
  // already known to be good.
  assign hdr    = (byte_cnt_q == 4'd0) ? rx_byte : frame_q[0];
  assign hdr_ok = (hdr == HDR_TOUCH) || (hdr == HDR_VALUE) || (hdr == HDR_PAGE);

  // Frame parser: the trailer check uses the two stored bytes before the one
  // arriving now.
  always_comb begin
    byte_cnt_d  = byte_cnt_q;
    page_d      = page_q;
    last_addr_d = last_addr_q;
    frame_we    = 1'b0;
    touch_we    = 1'b0;
    value_we    = 1'b0;
    event_d     = EV_NONE;
    if (accept) begin
      unique case (req)
        REQ_RX_BYTE: begin
          if (byte_cnt_q >= 4'd8) begin
            // A frame that ran past its length without a trailer drops this byte.
            byte_cnt_d = 4'd0;
          end else begin
            frame_we = 1'b1;
            if (!hdr_ok) begin
              byte_cnt_d = 4'd0;
            end else if (hdr == HDR_TOUCH && byte_cnt_q == 4'd6 &&
                         frame_q[4] == END_MARK && frame_q[5] == END_MARK &&
                         rx_byte == END_MARK) begin
              touch_we    = ({1'b0, frame_q[1]} < PagesC) &&
                            ({1'b0, frame_q[2]} < BtnSlotsC);
              page_d      = frame_q[1];
              last_addr_d = frame_q[2];
              byte_cnt_d  = 4'd0;
              event_d     = EV_TOUCH;
            end else if (hdr == HDR_VALUE && byte_cnt_q == 4'd7 &&
                         frame_q[5] == END_MARK && frame_q[6] == END_MARK &&
                         rx_byte == END_MARK) begin
              value_we   = ({1'b0, page_q} < PagesC) && ({1'b0, last_addr_q} < ValSlotsC);
              byte_cnt_d = 4'd0;
              event_d    = EV_VALUE;
            end else if (hdr == HDR_PAGE && byte_cnt_q == 4'd4 &&
                         frame_q[2] == END_MARK && frame_q[3] == END_MARK &&
                         rx_byte == END_MARK) begin
              page_d     = frame_q[1];
              byte_cnt_d = 4'd0;
              event_d    = EV_PAGE;
            end else begin
              byte_cnt_d = byte_cnt_q + 4'd1;
            end
          end
        end
        REQ_FRAME_ERR: byte_cnt_d = 4'd0;
        default: ;
      endcase
    end
  end

  // Host requests outside the table geometry read as zero and clear nothing.
  assign btn_ok = ({7'd0, query_page} < PagesC) && ({1'b0, query_addr} < BtnSlotsC);
  assign val_ok = ({7'd0, query_page} < PagesC) && ({1'b0, query_addr} < ValSlotsC);

  assign btn_rd_en  = accept && btn_ok &&
                      (req == REQ_READ_BTN || req == REQ_RDCLR_BTN);
  assign btn_clr_we = accept && btn_ok &&
                      (req == REQ_RDCLR_BTN || req == REQ_CLEAR_BTN);
  assign val_rd_en  = accept && val_ok && (req == REQ_READ_VALUE);

  // Flat table indexes; each is only used when it lies inside its table.
  assign touch_idx = 16'(frame_q[1]) * BtnMulC + 16'(frame_q[2]);
  assign value_idx = 16'(page_q) * ValMulC + 16'(last_addr_q);
  assign qbtn_idx  = 16'(query_page) * BtnMulC + 16'(query_addr);
  assign qval_idx  = 16'(query_page) * ValMulC + 16'(query_addr);

  // Write port selection; a transaction makes at most one write per table.
  always_comb begin
    btn_we = 1'b0;
    btn_wa = qbtn_idx[BTN_AW-1:0];
    btn_wd = 8'd0;
    val_we = 1'b0;
    val_wa = value_idx[VAL_AW-1:0];
    val_wd = frame_q[1];
    if (clearing_q) begin
      btn_we = (17'(clr_cnt_q) < BtnDepthC);
      btn_wa = clr_cnt_q[BTN_AW-1:0];
      val_we = (17'(clr_cnt_q) < ValDepthC);
      val_wa = clr_cnt_q[VAL_AW-1:0];
      val_wd = 8'd0;
    end else begin
      if (touch_we) begin
        btn_we = 1'b1;
        btn_wa = touch_idx[BTN_AW-1:0];
        btn_wd = frame_q[3];
      end else if (btn_clr_we) begin
        btn_we = 1'b1;
      end
      val_we = value_we;
    end
  end

  // Button table: one write port, one registered read-first read port.
  always_ff @(posedge clk_i) begin
    if (btn_we) begin
      btn_mem[btn_wa] <= btn_wd;
    end
    if (btn_rd_en) begin
      btn_rd_q <= btn_mem[qbtn_idx[BTN_AW-1:0]];
    end
  end

  // Value table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (val_rd_en) begin
      val_rd_q <= val_mem[qval_idx[VAL_AW-1:0]];
    end
  end

  // Frame byte buffer.
  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_q[byte_cnt_q[2:0]] <= rx_byte;
    end
  end

  // Control state, parser registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      byte_cnt_q  <= 4'd0;
      page_q      <= 8'd0;
      last_addr_q <= 8'd0;
      out_valid_q <= 1'b0;
      out_btn_q   <= 1'b0;
      out_val_q   <= 1'b0;
      out_event_q <= EV_NONE;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + CLR_AW'(1);
        if (clr_cnt_q == ClrLastC) begin
          clearing_q <= 1'b0;
        end
      end
      byte_cnt_q  <= byte_cnt_d;
      page_q      <= page_d;
      last_addr_q <= last_addr_d;
      if (accept) begin
        out_valid_q <= 1'b1;
        out_btn_q   <= btn_rd_en;
        out_val_q   <= val_rd_en;
        out_event_q <= event_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Page and last button only change on an accepted transaction, so they always
  // match the result held in the output register.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {last_addr_q, page_q,
                            out_val_q ? val_rd_q : 8'd0,
                            out_btn_q ? btn_rd_q : 8'd0};
  assign m_axis_tuser_o  = out_event_q;

  // No transaction may be taken while the tables are being cleared.
  `TDFP_ASSERT_ALWAYS(a_no_accept_in_clear, s_axis_tready_o |-> !clearing_q, "accept during clearing pass")
  // A completed frame never carries table read data.
  `TDFP_ASSERT(a_event_no_read, m_axis_tvalid_o && (m_axis_tuser_o != EV_NONE) |-> m_axis_tdata_o[15:0] == 16'd0, "frame event with read data")
  // The clearing pass ends only after visiting the last entry.
  `TDFP_ASSERT(a_clear_complete, $fell(clearing_q) |-> $past(clr_cnt_q) == ClrLastC, "clearing pass ended early")

endmodule
